// ===== sv/wmjc_pkg.sv =====
package wmjc_pkg;

   localparam int unsigned HEIGHT_W = 16;
   localparam int unsigned COST_W   = 32;
   localparam int unsigned LIMIT_W  = 5;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

// ===== sv/wmjc_if.sv =====
interface wmjc_req_if
   import wmjc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] height;
   logic                is_last;

   modport source (output valid, output height, output is_last, input ready);
   modport sink   (input valid, input height, input is_last, output ready);
endinterface

interface wmjc_rsp_if
   import wmjc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] min_cost;
   logic              saturated;

   modport source (output valid, output min_cost, output saturated, input ready);
   modport sink   (input valid, input min_cost, input saturated, output ready);
endinterface

// ===== sv/wmjc_ram.sv =====
module wmjc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/windowed_min_jump_cost_core.sv =====
// Flow: a request is accepted in IDLE; the first item of a sequence goes straight to COMMIT, others
// first pass through SCAN, which covers span = min(entries in the history, effective jump limit)
// entries. One history entry per cycle is read and scored by a single abs-diff/add/compare unit
// over a registered-read RAM. A new item is accepted only after the previous one leaves COMMIT;
// a last item waits in its commit step while the previous result is unread.
// Reset (synchronous): empty history, flag clear, jump limit 1, no pending result.
module windowed_min_jump_cost_core
   import wmjc_pkg::*;
#(
   parameter int unsigned MAX_JUMP = 16
) (
   input  logic              clock,
   input  logic              reset,
   wmjc_req_if.sink          req_if,
   wmjc_rsp_if.source        rsp_if,
   input  logic              csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   localparam int unsigned SLOT_W = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_JUMP + 1);
   localparam int unsigned LW     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int unsigned ENT_W  = HEIGHT_W + COST_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_JUMP - 1);

   state_type           state_ff, state_in;
   logic [HEIGHT_W-1:0] h_ff, h_in;
   logic                last_ff, last_in;
   logic                first_ff, first_in;
   logic [SLOT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]       left_ff, left_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [COST_W-1:0]   best_ff, best_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                ovf_ff, ovf_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [COST_W-1:0]   rsp_cost_ff, rsp_cost_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic                ram_we, ram_re;
   logic [SLOT_W-1:0]   ram_raddr;
   logic [ENT_W-1:0]    ram_wdata, ram_rdata;

   logic [LW-1:0]       lim_raw, lim_eff, fill_ext, span;
   logic [HEIGHT_W-1:0] ph, diff;
   logic [COST_W:0]     sum;
   logic [COST_W-1:0]   cand, cost;
   logic                ovf_now;
   logic                req_acc;

   wmjc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_JUMP)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // effective window size
   assign lim_raw  = LW'(limit_ff);
   assign fill_ext = LW'(fill_ff);
   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = LW'(1);
      end else if (lim_raw > LW'(MAX_JUMP)) begin
         lim_eff = LW'(MAX_JUMP);
      end else begin
         lim_eff = lim_raw;
      end
      span = (fill_ext < lim_eff) ? fill_ext : lim_eff;
   end

   // shared scoring unit: |ph - h| + cost, saturated
   assign ph   = ram_rdata[COST_W +: HEIGHT_W];
   assign diff = (ph > h_ff) ? (ph - h_ff) : (h_ff - ph);
   assign sum  = {1'b0, ram_rdata[COST_W-1:0]} + (COST_W+1)'(diff);
   assign cand = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];

   assign cost      = first_ff ? '0 : best_ff;
   assign ovf_now   = ovf_ff | (!first_ff && (best_ff == COST_MAX));
   assign ram_wdata = {h_ff, cost};
   assign req_acc   = req_if.valid && req_if.ready;

   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      last_in     = last_ff;
      first_in    = first_ff;
      rd_ptr_in   = rd_ptr_ff;
      left_in     = left_ff;
      cmp_vld_in  = 1'b0;
      best_in     = best_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      limit_in    = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_if.ready;
      rsp_cost_in = rsp_cost_ff;
      rsp_sat_in  = rsp_sat_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_ptr_ff;
      req_if.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_acc) begin
               h_in     = req_if.height;
               last_in  = req_if.is_last;
               first_in = (fill_ff == '0);
               best_in  = COST_MAX;
               left_in  = span;
               // newest entry sits one slot behind the write slot
               rd_ptr_in = (slot_ff == '0) ? SLOT_LAST : slot_ff - 1'b1;
               state_in  = (fill_ff == '0) ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (left_ff != '0) begin
               ram_re     = 1'b1;
               cmp_vld_in = 1'b1;
               left_in    = left_ff - 1'b1;
               rd_ptr_in  = (rd_ptr_ff == '0) ? SLOT_LAST : rd_ptr_ff - 1'b1;
            end
            if (cmp_vld_ff) begin
               if (cand < best_ff) begin
                  best_in = cand;
               end
               if (left_ff == '0) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if (last_ff) begin
               // hold until the output register is free
               if (!rsp_vld_ff || rsp_if.ready) begin
                  rsp_vld_in  = 1'b1;
                  rsp_cost_in = cost;
                  rsp_sat_in  = ovf_now;
                  fill_in     = '0;
                  slot_in     = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_IDLE;
               end
            end else begin
               ram_we   = 1'b1;
               ovf_in   = ovf_now;
               slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
               fill_in  = (fill_ff == CNT_W'(MAX_JUMP)) ? fill_ff : fill_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         slot_ff    <= '0;
         fill_ff    <= '0;
         ovf_ff     <= 1'b0;
         limit_ff   <= LIMIT_W'(1);
         rsp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmp_vld_in;
         slot_ff    <= slot_in;
         fill_ff    <= fill_in;
         ovf_ff     <= ovf_in;
         limit_ff   <= limit_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      last_ff     <= last_in;
      first_ff    <= first_in;
      rd_ptr_ff   <= rd_ptr_in;
      left_ff     <= left_in;
      best_ff     <= best_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.min_cost  = rsp_cost_ff;
   assign rsp_if.saturated = rsp_sat_ff;

endmodule

// ===== sv/wmjc_checker.sv =====
module wmjc_checker
   import wmjc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COST_W-1:0] rsp_min_cost,
   input logic              rsp_saturated
);

   // pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_min_cost) && $stable(rsp_saturated)))
      else $error("result dropped or changed while stalled");

   // one transaction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("bad state after reset");

   // a saturated cost always carries the flag
   a_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_min_cost == COST_MAX)) |-> rsp_saturated)
      else $error("saturated cost without flag");

endmodule

bind windowed_min_jump_cost_core wmjc_checker u_wmjc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_min_cost  (rsp_if.min_cost),
   .rsp_saturated (rsp_if.saturated)
);

// ===== tb/tb_windowed_min_jump_cost_core.sv =====
`timescale 1ns / 1ps

module tb_windowed_min_jump_cost_core;
   import wmjc_pkg::*;

   localparam int MAX_JUMP     = 16;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_PAD    = 40;
   localparam int HOLD_LEN     = 400;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef enum logic {
      ROW_CFG,
      ROW_ITEM
   } row_kind_type;

   typedef enum int {
      HS_FULL,
      HS_NEAR,
      HS_EXTREME,
      HS_LOW
   } height_style_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [HEIGHT_W-1:0] value;
      logic                is_last;
      logic                typed;
      logic [COST_W-1:0]   cost;
      logic                sat;
   } stim_row_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              sat;
   } cost_result_type;

   localparam int DIRECTED_N = 27;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      // jump limit 1 after reset
      '{ROW_ITEM, 16'd1234,  1'b1, 1'b1, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd0,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b1, 1'b1, 32'd65535,  1'b0},
      '{ROW_CFG,  16'd16,    1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd100,   1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd50,    1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd300,   1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd7,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd0,     1'b1, 1'b0, 32'd0,      1'b0},
      // zero limit behaves as one
      '{ROW_CFG,  16'd0,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd0,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd0,     1'b1, 1'b1, 32'd131070, 1'b0},
      // oversized limit clamps to MAX_JUMP
      '{ROW_CFG,  16'd31,    1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd10,    1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd20,    1'b1, 1'b0, 32'd0,      1'b0},
      '{ROW_CFG,  16'd17,    1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd5,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd5,     1'b1, 1'b1, 32'd0,      1'b0},
      '{ROW_CFG,  16'd2,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd0,     1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b0, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd0,     1'b1, 1'b0, 32'd0,      1'b0},
      '{ROW_ITEM, 16'd65535, 1'b1, 1'b1, 32'd0,      1'b0}
   };

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   wmjc_req_if req_if ();
   wmjc_rsp_if rsp_if ();

   windowed_min_jump_cost_core #(
      .MAX_JUMP (MAX_JUMP)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [HEIGHT_W-1:0] height_ring [MAX_JUMP];
   logic [COST_W-1:0]   cost_ring   [MAX_JUMP];
   int                  ring_fill  = 0;
   int                  ring_slot  = 0;
   logic                ring_ovf   = 1'b0;
   logic [LIMIT_W-1:0]  jump_lim   = 5'd1;

   stim_row_type    sent_items     [$];
   cost_result_type expected_costs [$];

   int   err_count  = 0;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_token = 1'b0;

   task automatic report_mismatch(input string what, input logic [COST_W-1:0] got,
                                  input logic [COST_W-1:0] want);
      $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
      err_count++;
   endtask

   task automatic score_height(input logic [HEIGHT_W-1:0] h, input logic last,
                               output bit has_result, output cost_result_type res);
      int                  lim;
      int                  span;
      int                  sl;
      logic [HEIGHT_W-1:0] ph;
      logic [HEIGHT_W-1:0] diff;
      logic [COST_W:0]     cand;
      logic [COST_W:0]     best;
      logic [COST_W-1:0]   c;
      lim = int'(jump_lim);
      if (lim == 0) lim = 1;
      if (lim > MAX_JUMP) lim = MAX_JUMP;
      if (ring_fill == 0) begin
         c = '0;
      end else begin
         span = (ring_fill < lim) ? ring_fill : lim;
         best = {1'b0, COST_MAX};
         for (int j = 1; j <= span; j++) begin
            sl   = (ring_slot + MAX_JUMP - j) % MAX_JUMP;
            ph   = height_ring[sl];
            diff = (ph > h) ? ph - h : h - ph;
            cand = {1'b0, cost_ring[sl]} + {{(COST_W+1-HEIGHT_W){1'b0}}, diff};
            if (cand > {1'b0, COST_MAX}) cand = {1'b0, COST_MAX};
            if (cand < best) best = cand;
         end
         c = best[COST_W-1:0];
         if (c == COST_MAX) ring_ovf = 1'b1;
      end
      has_result = last;
      res.cost   = c;
      res.sat    = ring_ovf;
      if (last) begin
         ring_fill = 0;
         ring_slot = 0;
         ring_ovf  = 1'b0;
      end else begin
         height_ring[ring_slot] = h;
         cost_ring[ring_slot]   = c;
         ring_slot = (ring_slot + 1) % MAX_JUMP;
         if (ring_fill < MAX_JUMP) ring_fill++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin : monitor
      stim_row_type    note;
      cost_result_type pred;
      cost_result_type want;
      bit              has;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("windowed_min_jump_cost_core test failed");
         $finish;
      end else if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            note = (sent_items.size() != 0) ? sent_items.pop_front() : '0;
            score_height(req_if.height, req_if.is_last, has, pred);
            if (has) begin
               if (note.typed) begin
                  want.cost = note.cost;
                  want.sat  = note.sat;
               end else begin
                  want = pred;
               end
               expected_costs.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_costs.size() == 0) begin
               report_mismatch("unexpected result, min_cost", rsp_if.min_cost, '0);
            end else begin
               want = expected_costs.pop_front();
               if (rsp_if.min_cost !== want.cost)
                  report_mismatch("min_cost", rsp_if.min_cost, want.cost);
               if (rsp_if.saturated !== want.sat)
                  report_mismatch("saturated", {31'd0, rsp_if.saturated}, {31'd0, want.sat});
            end
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   initial begin : receiver
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_LEN;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_item(input logic [HEIGHT_W-1:0] h, input logic last,
                            input stim_row_type note);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      sent_items.push_back(note);
      req_if.valid   <= 1'b1;
      req_if.height  <= h;
      req_if.is_last <= last;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // wait until every result is back and the core has settled
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_costs.size() != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      jump_lim = v;
   endtask

   function automatic logic [HEIGHT_W-1:0] pick_height(input height_style_type style,
                                                       input logic [HEIGHT_W-1:0] prev);
      logic [HEIGHT_W-1:0] h;
      case (style)
         HS_NEAR:    h = prev + HEIGHT_W'($urandom_range(0, 64)) - HEIGHT_W'(32);
         HS_EXTREME: h = $urandom_range(1) ? '1 : '0;
         HS_LOW:     h = HEIGHT_W'($urandom_range(0, 15));
         default:    h = HEIGHT_W'($urandom);
      endcase
      return h;
   endfunction

   task automatic run_phase(input int n_items, input int idle_pct, input int stall,
                            input logic [LIMIT_W-1:0] lim, input int max_len,
                            input bit long_hold);
      int                  sent;
      int                  len;
      height_style_type    style;
      logic [HEIGHT_W-1:0] h;
      write_limit(lim);
      send_idle_pct = idle_pct;
      stall_pct <= stall;
      if (long_hold) hold_token <= ~hold_token;
      sent = 0;
      h    = HEIGHT_W'($urandom);
      while (sent < n_items) begin
         len   = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, max_len);
         style = height_style_type'($urandom_range(0, 3));
         for (int k = 0; k < len; k++) begin
            h = pick_height(style, h);
            send_item(h, k == len - 1, '0);
         end
         sent += len;
      end
   endtask

   initial begin : stimulus
      stim_row_type row;
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_if.valid   <= 1'b0;
      req_if.height  <= '0;
      req_if.is_last <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CFG)
            write_limit(row.value[LIMIT_W-1:0]);
         else
            send_item(row.value, row.is_last, row);
      end

      // single-item sequence right after another single-item sequence
      row       = '0;
      row.kind  = ROW_ITEM;
      row.typed = 1'b1;
      send_item(16'd9, 1'b1, row);

      run_phase(200, 0,  0,  5'd16, 40, 1'b0);
      run_phase(200, 56, 0,  5'($urandom_range(2, 15)), 24, 1'b0);
      run_phase(200, 0,  56, 5'd31, 24, 1'b0);
      run_phase(200, 31, 31, 5'd1,  24, 1'b0);
      run_phase(150, 0,  0,  5'd4,  4,  1'b1);
      run_phase(100, 31, 31, 5'($urandom_range(0, 31)), 20, 1'b0);
      run_phase(60,  0,  0,  5'd0,  12, 1'b0);

      wait_drain();
      if (err_count == 0)
         $display("windowed_min_jump_cost_core test passed");
      else
         $display("windowed_min_jump_cost_core test failed");
      $finish;
   end

endmodule
